// ===== design/nested_brace_body_scanner_defines.svh =====
// Assertion macros for the nested brace body scanner checker.
// Depends on nothing; included by the checker file only.
`ifndef NESTED_BRACE_BODY_SCANNER_DEFINES_SVH
`define NESTED_BRACE_BODY_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define NBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define NBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/nbs_pkg.sv =====
// Shared types and constants for the nested brace body scanner.
// No dependencies; used by nbs_step, the top level, the scoreboard and the testbench.
package nbs_pkg;

   localparam int CHAR_W       = 21;
   localparam int MAX_NEST_DEF = 255;

   // Character codes the scanner reacts to
   localparam logic [CHAR_W-1:0] CH_NUL    = 21'h00;
   localparam logic [CHAR_W-1:0] CH_NL     = 21'h0A;
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 21'h22;
   localparam logic [CHAR_W-1:0] CH_HASH   = 21'h23;
   localparam logic [CHAR_W-1:0] CH_SQUOTE = 21'h27;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h5C;
   localparam logic [CHAR_W-1:0] CH_LBRACE = 21'h7B;
   localparam logic [CHAR_W-1:0] CH_RBRACE = 21'h7D;

   typedef enum logic [1:0] {
      LEX_NORMAL  = 2'd0,
      LEX_COMMENT = 2'd1,
      LEX_LITERAL = 2'd2,
      LEX_ESCAPE  = 2'd3
   } lex_mode_type;

   // Scan state apart from the nesting depth
   typedef struct packed {
      logic         active;
      lex_mode_type mode;
      logic         quote_single;
      logic         any_consumed;
   } scan_state_type;

   localparam scan_state_type SCAN_IDLE = '{
      active:       1'b0,
      mode:         LEX_NORMAL,
      quote_single: 1'b0,
      any_consumed: 1'b0
   };

   // One result beat
   typedef struct packed {
      logic take_char;
      logic scan_end;
      logic token_found;
      logic nest_overflow;
   } step_result_type;

endpackage

// ===== design/nested_brace_body_scanner.sv =====
// An accepted request beat goes through the input register, then the result register, to
// its response beat. Throughput: one character per cycle while the response side does not
// stall, set by the combinational scan state update between the two registers. Reset
// (synchronous) empties both registers and returns the scanner to idle with depth zero.
// Depends on nbs_pkg and nbs_step.
module nested_brace_body_scanner #(
   parameter int MAX_NEST = nbs_pkg::MAX_NEST_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [nbs_pkg::CHAR_W-1:0]   req_character,
   input  logic                         req_scan_start,
   input  logic                         req_body_wanted,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_take_char,
   output logic                         rsp_scan_end,
   output logic                         rsp_token_found,
   output logic                         rsp_nest_overflow
);

   localparam int DEPTH_W = $clog2(MAX_NEST + 1);

   logic                         in_vld_ff, in_vld_in;
   logic [nbs_pkg::CHAR_W-1:0]   in_char_ff;
   logic                         in_start_ff;
   logic                         in_wanted_ff;
   nbs_pkg::scan_state_type      state_ff, state_in;
   logic [DEPTH_W-1:0]           depth_ff, depth_in;
   logic                         out_vld_ff, out_vld_in;
   nbs_pkg::step_result_type     out_res_ff, out_res_in;
   logic                         advance;
   logic                         in_take;

   // Move the held beat into the result register when that register frees up
   assign advance   = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign in_take   = req_valid && !req_stall;
   assign in_vld_in = in_take || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && rsp_stall);

   nbs_step #(
      .MAX_NEST(MAX_NEST)
   ) u_step (
      .cur_state  (state_ff),
      .cur_depth  (depth_ff),
      .character  (in_char_ff),
      .scan_start (in_start_ff),
      .body_wanted(in_wanted_ff),
      .nxt_state  (state_in),
      .nxt_depth  (depth_in),
      .result     (out_res_in)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= nbs_pkg::SCAN_IDLE;
         depth_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            state_ff <= state_in;
            depth_ff <= depth_in;
         end
      end
   end

   // Payload: capture on accept, hold on stall
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_char_ff   <= req_character;
         in_start_ff  <= req_scan_start;
         in_wanted_ff <= req_body_wanted;
      end
      if (advance) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_take_char     = out_res_ff.take_char;
   assign rsp_scan_end      = out_res_ff.scan_end;
   assign rsp_token_found   = out_res_ff.token_found;
   assign rsp_nest_overflow = out_res_ff.nest_overflow;

endmodule

// ===== design/nbs_step.sv =====
// Combinational step of the scanner: next scan state, depth and result for one character.
// Depends on nbs_pkg.
module nbs_step #(
   parameter int MAX_NEST = nbs_pkg::MAX_NEST_DEF,
   localparam int DEPTH_W = $clog2(MAX_NEST + 1)
) (
   input  nbs_pkg::scan_state_type  cur_state,
   input  logic [DEPTH_W-1:0]       cur_depth,
   input  logic [nbs_pkg::CHAR_W-1:0] character,
   input  logic                     scan_start,
   input  logic                     body_wanted,
   output nbs_pkg::scan_state_type  nxt_state,
   output logic [DEPTH_W-1:0]       nxt_depth,
   output nbs_pkg::step_result_type result
);

   nbs_pkg::scan_state_type eff_state;
   logic [DEPTH_W-1:0]      eff_depth;
   logic                    is_nul;
   logic                    is_nl;
   logic                    is_close_quote;
   logic                    depth_zero;
   logic                    depth_full;

   // Apply scan start and decode the character
   always_comb begin
      eff_state = cur_state;
      eff_depth = cur_depth;
      if (scan_start) begin
         eff_state        = nbs_pkg::SCAN_IDLE;
         eff_state.active = body_wanted;
         eff_depth        = '0;
      end
      is_nul         = (character == nbs_pkg::CH_NUL);
      is_nl          = (character == nbs_pkg::CH_NL);
      is_close_quote = eff_state.quote_single ? (character == nbs_pkg::CH_SQUOTE)
                                              : (character == nbs_pkg::CH_DQUOTE);
      depth_zero     = (eff_depth == '0);
      depth_full     = (eff_depth == DEPTH_W'(MAX_NEST));
   end

   // Next state
   always_comb begin
      nxt_state = eff_state;
      nxt_depth = eff_depth;
      if (eff_state.active) begin
         if (is_nul) begin
            nxt_state = nbs_pkg::SCAN_IDLE;
            nxt_depth = '0;
         end else begin
            case (eff_state.mode)
               nbs_pkg::LEX_COMMENT: begin
                  // newline closes the comment and is taken as plain text
                  if (is_nl) begin
                     nxt_state.mode = nbs_pkg::LEX_NORMAL;
                  end
                  nxt_state.any_consumed = 1'b1;
               end
               nbs_pkg::LEX_LITERAL: begin
                  if (character == nbs_pkg::CH_BSLASH) begin
                     nxt_state.mode = nbs_pkg::LEX_ESCAPE;
                  end else if (is_close_quote) begin
                     nxt_state.mode = nbs_pkg::LEX_NORMAL;
                  end
                  nxt_state.any_consumed = 1'b1;
               end
               nbs_pkg::LEX_ESCAPE: begin
                  nxt_state.mode         = nbs_pkg::LEX_LITERAL;
                  nxt_state.any_consumed = 1'b1;
               end
               default: begin
                  if (character == nbs_pkg::CH_RBRACE && depth_zero) begin
                     nxt_state = nbs_pkg::SCAN_IDLE;
                     nxt_depth = '0;
                  end else begin
                     nxt_state.any_consumed = 1'b1;
                     if (character == nbs_pkg::CH_HASH) begin
                        nxt_state.mode = nbs_pkg::LEX_COMMENT;
                     end else if (character == nbs_pkg::CH_SQUOTE ||
                                  character == nbs_pkg::CH_DQUOTE) begin
                        nxt_state.mode         = nbs_pkg::LEX_LITERAL;
                        nxt_state.quote_single = (character == nbs_pkg::CH_SQUOTE);
                     end else if (character == nbs_pkg::CH_LBRACE) begin
                        // saturate at the bound
                        if (!depth_full) begin
                           nxt_depth = eff_depth + DEPTH_W'(1);
                        end
                     end else if (character == nbs_pkg::CH_RBRACE) begin
                        nxt_depth = eff_depth - DEPTH_W'(1);
                     end
                  end
               end
            endcase
         end
      end
   end

   // Result fields
   always_comb begin
      result = '0;
      if (scan_start && !body_wanted) begin
         result.scan_end = 1'b1;
      end else if (eff_state.active) begin
         if (is_nul) begin
            result.scan_end    = 1'b1;
            result.token_found = eff_state.any_consumed;
         end else begin
            case (eff_state.mode)
               nbs_pkg::LEX_COMMENT,
               nbs_pkg::LEX_LITERAL,
               nbs_pkg::LEX_ESCAPE: begin
                  result.take_char = 1'b1;
               end
               default: begin
                  if (character == nbs_pkg::CH_RBRACE && depth_zero) begin
                     result.scan_end    = 1'b1;
                     result.token_found = eff_state.any_consumed;
                  end else begin
                     result.take_char     = 1'b1;
                     result.nest_overflow = (character == nbs_pkg::CH_LBRACE) && depth_full;
                  end
               end
            endcase
         end
      end
   end

endmodule

// ===== design/nbs_checker.sv =====
// Port-level checks for the nested brace body scanner, bound to the top level.
// Depends on nested_brace_body_scanner_defines.svh and the top level's ports.
`include "nested_brace_body_scanner_defines.svh"

module nbs_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_take_char,
   input logic rsp_scan_end,
   input logic rsp_token_found,
   input logic rsp_nest_overflow
);

   logic       take_and_end;
   logic       found_beat;
   logic       ovf_beat;
   logic       stalled;
   logic [3:0] fields;

   // Gather the response beat's flags for the checks below
   assign take_and_end = rsp_take_char && rsp_scan_end;
   assign found_beat   = rsp_valid && rsp_token_found;
   assign ovf_beat     = rsp_valid && rsp_nest_overflow;
   assign stalled      = rsp_valid && rsp_stall;
   assign fields       = {rsp_take_char, rsp_scan_end, rsp_token_found, rsp_nest_overflow};

   // A character is never both taken and the end of the scan
   `NBS_ASSERT_NOW(a_take_xor_end, clock, reset, rsp_valid, !take_and_end, "taken and ended")

   // A found token is reported only where the scan ends
   `NBS_ASSERT_NOW(a_found_at_end, clock, reset, found_beat, rsp_scan_end, "found without end")

   // Overflow comes only from a consumed open brace
   `NBS_ASSERT_NOW(a_ovf_taken, clock, reset, ovf_beat, rsp_take_char, "overflow not taken")

   // Hold a stalled response beat
   `NBS_ASSERT_NEXT(a_hold, clock, reset, stalled, rsp_valid && $stable(fields), "stall not held")

endmodule

bind nested_brace_body_scanner nbs_checker u_nbs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_take_char    (rsp_take_char),
   .rsp_scan_end     (rsp_scan_end),
   .rsp_token_found  (rsp_token_found),
   .rsp_nest_overflow(rsp_nest_overflow)
);

// ===== sim/brace_scan_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the nested brace body scanner: follows both channels, predicts each
// response beat from the accepted request beats and counts field mismatches.
// Depends on nbs_pkg.
module brace_scan_checker #(
   parameter int NEST_LIMIT = nbs_pkg::MAX_NEST_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [nbs_pkg::CHAR_W-1:0] req_character,
   input  logic                       req_scan_start,
   input  logic                       req_body_wanted,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_take_char,
   input  logic                       rsp_scan_end,
   input  logic                       rsp_token_found,
   input  logic                       rsp_nest_overflow,
   output int                         error_count,
   output int                         pending_count,
   output int                         beats_checked,
   output int                         ends_seen,
   output int                         tokens_seen,
   output int                         overflows_seen
);

   // Predicted scanner state
   logic                  scanning;
   nbs_pkg::lex_mode_type mode;
   logic                  single_quote;
   logic [15:0]           depth;
   logic                  consumed;

   // Verdicts for accepted characters, oldest first
   nbs_pkg::step_result_type char_verdicts[$];

   function automatic void clear_scan();
      scanning     = 1'b0;
      mode         = nbs_pkg::LEX_NORMAL;
      single_quote = 1'b0;
      depth        = '0;
      consumed     = 1'b0;
   endfunction

   // Work out the response to one character and advance the predicted state
   function automatic nbs_pkg::step_result_type judge_char(
      input logic [nbs_pkg::CHAR_W-1:0] ch,
      input logic                       start,
      input logic                       wanted);
      nbs_pkg::step_result_type   r;
      logic [nbs_pkg::CHAR_W-1:0] closing;
      r = '0;
      if (start) begin
         clear_scan();
         if (!wanted) begin
            r.scan_end = 1'b1;
            return r;
         end
         scanning = 1'b1;
      end
      if (!scanning) return r;

      // end of input stops the scan in every mode
      if (ch == nbs_pkg::CH_NUL) begin
         r.scan_end    = 1'b1;
         r.token_found = consumed;
         clear_scan();
         return r;
      end

      closing = single_quote ? nbs_pkg::CH_SQUOTE : nbs_pkg::CH_DQUOTE;
      case (mode)
         nbs_pkg::LEX_COMMENT: begin
            // the newline drops out of the comment and is handled below
            if (ch != nbs_pkg::CH_NL) begin
               r.take_char = 1'b1;
               consumed    = 1'b1;
               return r;
            end
            mode = nbs_pkg::LEX_NORMAL;
         end
         nbs_pkg::LEX_LITERAL: begin
            if (ch == nbs_pkg::CH_BSLASH) mode = nbs_pkg::LEX_ESCAPE;
            else if (ch == closing) mode = nbs_pkg::LEX_NORMAL;
            r.take_char = 1'b1;
            consumed    = 1'b1;
            return r;
         end
         nbs_pkg::LEX_ESCAPE: begin
            mode        = nbs_pkg::LEX_LITERAL;
            r.take_char = 1'b1;
            consumed    = 1'b1;
            return r;
         end
         default: ;
      endcase

      // normal mode: an unmatched closing brace ends the body
      if (ch == nbs_pkg::CH_RBRACE && depth == '0) begin
         r.scan_end    = 1'b1;
         r.token_found = consumed;
         clear_scan();
         return r;
      end
      if (ch == nbs_pkg::CH_HASH) begin
         mode = nbs_pkg::LEX_COMMENT;
      end else if (ch == nbs_pkg::CH_SQUOTE || ch == nbs_pkg::CH_DQUOTE) begin
         mode         = nbs_pkg::LEX_LITERAL;
         single_quote = (ch == nbs_pkg::CH_SQUOTE);
      end else if (ch == nbs_pkg::CH_LBRACE) begin
         if (depth >= 16'(NEST_LIMIT)) begin
            depth           = 16'(NEST_LIMIT);
            r.nest_overflow = 1'b1;
         end else begin
            depth = depth + 16'd1;
         end
      end else if (ch == nbs_pkg::CH_RBRACE) begin
         depth = depth - 16'd1;
      end
      r.take_char = 1'b1;
      consumed    = 1'b1;
      return r;
   endfunction

   task automatic check_field(input string name, input logic exp, input logic act);
      if (act !== exp) begin
         $error("%s: expected %b, got %b", name, exp, act);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      nbs_pkg::step_result_type want;
      if (reset) begin
         clear_scan();
         char_verdicts.delete();
      end else begin
         // compare a response beat with the oldest verdict before adding new ones
         if (rsp_valid && !rsp_stall) begin
            if (char_verdicts.size() == 0) begin
               $error("response beat with no request beat waiting");
               error_count++;
            end else begin
               want = char_verdicts.pop_front();
               check_field("take_char", want.take_char, rsp_take_char);
               check_field("scan_end", want.scan_end, rsp_scan_end);
               check_field("token_found", want.token_found, rsp_token_found);
               check_field("nest_overflow", want.nest_overflow, rsp_nest_overflow);
               beats_checked++;
               if (want.scan_end) ends_seen++;
               if (want.token_found) tokens_seen++;
               if (want.nest_overflow) overflows_seen++;
            end
         end
         if (req_valid && !req_stall) begin
            want = judge_char(req_character, req_scan_start, req_body_wanted);
            char_verdicts.push_back(want);
         end
      end
      pending_count = char_verdicts.size();
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the scanner testbench: clock, reset, request stimulus, response stalls and
// the verdict. Depends on nbs_pkg, nested_brace_body_scanner and brace_scan_checker.
module testbench;

   localparam int                         NEST_LIMIT  = nbs_pkg::MAX_NEST_DEF;
   localparam int                         CYCLE_LIMIT = 400000;
   localparam logic [nbs_pkg::CHAR_W-1:0] CH_PLAIN    = 21'h61;
   localparam logic [nbs_pkg::CHAR_W-1:0] CH_TOP      = 21'h1FFFFF;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [nbs_pkg::CHAR_W-1:0] req_character;
   logic                       req_scan_start;
   logic                       req_body_wanted;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_take_char;
   logic                       rsp_scan_end;
   logic                       rsp_token_found;
   logic                       rsp_nest_overflow;

   int error_count;
   int pending_count;
   int beats_checked;
   int ends_seen;
   int tokens_seen;
   int overflows_seen;
   int items_sent;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;

   nested_brace_body_scanner #(
      .MAX_NEST(NEST_LIMIT)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_character     (req_character),
      .req_scan_start    (req_scan_start),
      .req_body_wanted   (req_body_wanted),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_take_char     (rsp_take_char),
      .rsp_scan_end      (rsp_scan_end),
      .rsp_token_found   (rsp_token_found),
      .rsp_nest_overflow (rsp_nest_overflow)
   );

   brace_scan_checker #(
      .NEST_LIMIT(NEST_LIMIT)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_character     (req_character),
      .req_scan_start    (req_scan_start),
      .req_body_wanted   (req_body_wanted),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_take_char     (rsp_take_char),
      .rsp_scan_end      (rsp_scan_end),
      .rsp_token_found   (rsp_token_found),
      .rsp_nest_overflow (rsp_nest_overflow),
      .error_count       (error_count),
      .pending_count     (pending_count),
      .beats_checked     (beats_checked),
      .ends_seen         (ends_seen),
      .tokens_seen       (tokens_seen),
      .overflows_seen    (overflows_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the response channel at the current rate
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d beats outstanding",
                  cycle_count, pending_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one beat after random idle cycles; return at the falling edge after acceptance
   task automatic send_char(input logic [nbs_pkg::CHAR_W-1:0] ch, input logic start,
                            input logic wanted);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_character   <= ch;
      req_scan_start  <= start;
      req_body_wanted <= wanted;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   // Weighted character mix: plain text, full-range code points and every special code
   function automatic logic [nbs_pkg::CHAR_W-1:0] pick_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return nbs_pkg::CHAR_W'($urandom_range(126, 32));
      if (roll < 40) return nbs_pkg::CHAR_W'($urandom());
      if (roll < 54) return nbs_pkg::CH_LBRACE;
      if (roll < 62) return nbs_pkg::CH_RBRACE;
      if (roll < 68) return nbs_pkg::CH_HASH;
      if (roll < 74) return nbs_pkg::CH_NL;
      if (roll < 80) return nbs_pkg::CH_SQUOTE;
      if (roll < 86) return nbs_pkg::CH_DQUOTE;
      if (roll < 93) return nbs_pkg::CH_BSLASH;
      if (roll < 96) return nbs_pkg::CH_NUL;
      return nbs_pkg::CHAR_W'($urandom_range(127));
   endfunction

   // One scan: a start beat, a random body with an occasional restart, then a close-out
   task automatic random_scan();
      int len;
      int k;
      len = $urandom_range(24, 1);
      send_char(pick_char(), 1'b1, $urandom_range(9) != 0);
      for (k = 1; k < len; k++) begin
         send_char(pick_char(), $urandom_range(39) == 0, 1'($urandom_range(1)));
      end
      repeat ($urandom_range(3)) send_char(nbs_pkg::CH_RBRACE, 1'b0, 1'($urandom_range(1)));
      send_char(nbs_pkg::CH_NUL, 1'b0, 1'($urandom_range(1)));
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct, input int quota);
      int goal;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      goal           = items_sent + quota;
      while (items_sent < goal) random_scan();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_character   = '0;
      req_scan_start  = 1'b0;
      req_body_wanted = 1'b0;
      rsp_stall       = 1'b0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      items_sent      = 0;
      cycle_count     = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // token not wanted, then empty bodies ended by a closing brace and by end of input
      send_char(CH_PLAIN, 1'b1, 1'b0);
      send_char(nbs_pkg::CH_RBRACE, 1'b1, 1'b1);
      send_char(nbs_pkg::CH_NUL, 1'b1, 1'b1);

      // walk a body through comment, both literals and an escape
      send_char(CH_PLAIN, 1'b1, 1'b1);
      send_char(nbs_pkg::CH_LBRACE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_HASH, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_RBRACE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_NL, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_DQUOTE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_RBRACE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_BSLASH, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_DQUOTE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_DQUOTE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_SQUOTE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_DQUOTE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_SQUOTE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_RBRACE, 1'b0, 1'b0);
      send_char(CH_TOP, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_RBRACE, 1'b0, 1'b0);

      // end of input after a backslash, inside a comment and inside a literal
      send_char(nbs_pkg::CH_SQUOTE, 1'b1, 1'b1);
      send_char(nbs_pkg::CH_BSLASH, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_NUL, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_HASH, 1'b1, 1'b1);
      send_char(nbs_pkg::CH_NUL, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_DQUOTE, 1'b1, 1'b1);
      send_char(nbs_pkg::CH_NUL, 1'b0, 1'b0);

      // restart mid-scan clears the depth, so the brace ends the new scan
      send_char(nbs_pkg::CH_LBRACE, 1'b1, 1'b1);
      send_char(nbs_pkg::CH_RBRACE, 1'b1, 1'b1);

      // drive the depth into saturation and back out
      send_char(nbs_pkg::CH_LBRACE, 1'b1, 1'b1);
      repeat (NEST_LIMIT + 1) send_char(nbs_pkg::CH_LBRACE, 1'b0, 1'b0);
      repeat (3) send_char(nbs_pkg::CH_RBRACE, 1'b0, 1'b0);
      send_char(nbs_pkg::CH_NUL, 1'b0, 1'b0);

      random_phase(0, 0, 140);
      random_phase(87, 0, 140);
      random_phase(0, 87, 140);
      random_phase(33, 33, 140);

      // drain, then allow for the pipeline latency
      req_valid      <= 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait (pending_count == 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d characters across four pacing mixes of sender gaps and stalls.",
               items_sent);
      $display("Checked %0d beats: %0d scan ends, %0d with a body token, %0d overflows.",
               beats_checked, ends_seen, tokens_seen, overflows_seen);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
